// ===== src/ille_pkg.sv =====
// Shared constants for the indexed linked list engine: field widths,
// request mode codes and result status codes.
// No dependencies.
package ille_pkg;

  localparam int MODE_W   = 3;
  localparam int POS_W    = 11;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // Request modes carried on the input channel.
  localparam logic [MODE_W-1:0] MODE_GET      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS_HEAD = 3'd1;
  localparam logic [MODE_W-1:0] MODE_APPEND   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_INS_AT   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DELETE   = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// ===== src/indexed_linked_list_engine.sv =====
// Indexed linked list engine: top level, holding the node stores, the walk
// sequencer and the result register.
// Depends on ille_pkg for field widths, mode codes and status codes.
//
// Usage. Each input transaction carries a mode, a list position and a value;
// each one produces exactly one output transaction with the value read, a
// status and the list length after the request. The list lives in two
// single-port-style synchronous memories (values and next links) with a
// registered read; deleted nodes are kept on a free list and are used
// again before any node that was never handed out.
// Sequencing: one request is in flight at a time. A request that is rejected
// at once goes straight to the result state. A get walks to position p, then
// reads the value. An insert takes a node (a recycled one first pops the free
// list) and writes its value; at position p > 0 it then walks to p - 1 and
// relinks, while an insert at the head relinks at once. A delete walks to the
// predecessor (none at the head), unhooks the node and frees it. An append
// walks the whole list. The time is set by the link walk, one link memory
// read per node, so the slowest request is one that walks the whole list.
// in_ready is high whenever the sequencer is idle, so the next request is
// taken while a finished result still waits in the output register. When the
// receiver stalls, a second result waits in the sequencer until the output
// register is free, and no further input is taken meanwhile.
// Reset empties the list, the free list and the fresh node counter at once;
// the memories are not cleared, since no entry is read before it is written.
module indexed_linked_list_engine #(
  parameter int CAPACITY = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ille_pkg::MODE_W-1:0]         in_mode,
  input  logic [ille_pkg::POS_W-1:0]          in_position,
  input  logic signed [ille_pkg::VALUE_W-1:0] in_item_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ille_pkg::VALUE_W-1:0] out_read_value,
  output logic [ille_pkg::STATUS_W-1:0]       out_status,
  output logic [ille_pkg::POS_W-1:0]          out_length_after
);

  // Node addresses, node pointers (which also hold the null code) and counts.
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int PTR_W  = $clog2(CAPACITY) + 1;
  localparam int LEN_W  = $clog2(CAPACITY + 1);
  localparam int POS_W  = ille_pkg::POS_W;
  localparam int CMP_W  = (LEN_W > POS_W) ? LEN_W : POS_W;
  localparam int VAL_W  = ille_pkg::VALUE_W;

  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(CAPACITY);
  localparam logic [LEN_W-1:0] CAP_LEN  = LEN_W'(CAPACITY);

  typedef enum logic [4:0] {
    S_IDLE, S_ALLOC, S_ALLOCW, S_PLACE, S_WALK, S_STEP, S_GRD, S_GWAIT,
    S_IRD, S_IW1, S_IW2, S_DHEAD, S_DPREV, S_DGETV, S_DLINK, S_DFREE, S_RESP
  } state_t;

  typedef enum logic [1:0] {OP_GET, OP_INS, OP_DEL} op_t;

  // Node stores.
  logic [VAL_W-1:0] value_mem [CAPACITY];
  logic [PTR_W-1:0] link_mem  [CAPACITY];

  logic              link_re, link_we, value_re, value_we;
  logic [ADDR_W-1:0] link_raddr, link_waddr, value_raddr, value_waddr;
  logic [PTR_W-1:0]  link_wdata;
  logic [VAL_W-1:0]  value_wdata;
  logic [PTR_W-1:0]  link_rd_r;
  logic [VAL_W-1:0]  value_rd_r;

  // Sequencer and list state.
  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [PTR_W-1:0]  cur_r, cur_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic [PTR_W-1:0]  new_r, new_nxt;
  logic [PTR_W-1:0]  victim_r, victim_nxt;
  logic              del_head_r, del_head_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  free_r, free_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  fresh_r, fresh_nxt;
  logic [VAL_W-1:0]  resp_value_r, resp_value_nxt;
  logic [ille_pkg::STATUS_W-1:0] resp_status_r, resp_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_value_r, out_value_nxt;
  logic [ille_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [POS_W-1:0]  out_len_r, out_len_nxt;

  logic [CMP_W-1:0]  pos_ext, len_ext;
  state_t            after_walk;

  assign pos_ext = CMP_W'(in_position);
  assign len_ext = CMP_W'(len_r);

  // Where a finished walk hands over, depending on the request in hand.
  always_comb begin
    case (op_r)
      OP_GET:  after_walk = S_GRD;
      OP_INS:  after_walk = S_IRD;
      OP_DEL:  after_walk = S_DPREV;
      default: after_walk = S_GRD;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    cur_nxt         = cur_r;
    cnt_nxt         = cnt_r;
    idx_nxt         = idx_r;
    new_nxt         = new_r;
    victim_nxt      = victim_r;
    del_head_nxt    = del_head_r;
    val_nxt         = val_r;
    head_nxt        = head_r;
    free_nxt        = free_r;
    len_nxt         = len_r;
    fresh_nxt       = fresh_r;
    resp_value_nxt  = resp_value_r;
    resp_status_nxt = resp_status_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_value_nxt   = out_value_r;
    out_status_nxt  = out_status_r;
    out_len_nxt     = out_len_r;
    link_re         = 1'b0;
    link_raddr      = cur_r[ADDR_W-1:0];
    link_we         = 1'b0;
    link_waddr      = cur_r[ADDR_W-1:0];
    link_wdata      = new_r;
    value_re        = 1'b0;
    value_raddr     = cur_r[ADDR_W-1:0];
    value_we        = 1'b0;
    value_waddr     = new_r[ADDR_W-1:0];
    value_wdata     = val_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          resp_value_nxt  = '1;
          resp_status_nxt = ille_pkg::ST_DONE;
          cur_nxt         = head_r;
          val_nxt         = in_item_value;
          case (in_mode)
            ille_pkg::MODE_GET: begin
              if (pos_ext < len_ext) begin
                op_nxt    = OP_GET;
                cnt_nxt   = LEN_W'(pos_ext);
                state_nxt = S_WALK;
              end else begin
                resp_status_nxt = ille_pkg::ST_RANGE;
                state_nxt       = S_RESP;
              end
            end
            ille_pkg::MODE_INS_HEAD, ille_pkg::MODE_APPEND, ille_pkg::MODE_INS_AT: begin
              if (in_mode == ille_pkg::MODE_INS_HEAD) begin
                idx_nxt = '0;
              end else if (in_mode == ille_pkg::MODE_APPEND) begin
                idx_nxt = len_r;
              end else begin
                idx_nxt = LEN_W'(pos_ext);
              end
              if (in_mode == ille_pkg::MODE_INS_AT && pos_ext > len_ext) begin
                resp_status_nxt = ille_pkg::ST_RANGE;
                state_nxt       = S_RESP;
              end else if (free_r != NULL_PTR) begin
                state_nxt = S_ALLOC;
              end else if (fresh_r < CAP_LEN) begin
                new_nxt   = PTR_W'(fresh_r);
                fresh_nxt = fresh_r + LEN_W'(1);
                state_nxt = S_PLACE;
              end else begin
                resp_status_nxt = ille_pkg::ST_FULL;
                state_nxt       = S_RESP;
              end
            end
            ille_pkg::MODE_DELETE: begin
              if (pos_ext < len_ext) begin
                if (pos_ext == '0) begin
                  victim_nxt   = head_r;
                  del_head_nxt = 1'b1;
                  state_nxt    = S_DHEAD;
                end else begin
                  del_head_nxt = 1'b0;
                  op_nxt       = OP_DEL;
                  cnt_nxt      = LEN_W'(pos_ext - CMP_W'(1));
                  state_nxt    = S_WALK;
                end
              end else begin
                resp_status_nxt = ille_pkg::ST_RANGE;
                state_nxt       = S_RESP;
              end
            end
            default: begin
              resp_status_nxt = ille_pkg::ST_RANGE;
              state_nxt       = S_RESP;
            end
          endcase
        end
      end
      S_ALLOC: begin
        link_re    = 1'b1;
        link_raddr = free_r[ADDR_W-1:0];
        state_nxt  = S_ALLOCW;
      end
      S_ALLOCW: begin
        new_nxt   = free_r;
        free_nxt  = link_rd_r;
        state_nxt = S_PLACE;
      end
      S_PLACE: begin
        value_we = 1'b1;
        if (idx_r == '0) begin
          link_we    = 1'b1;
          link_waddr = new_r[ADDR_W-1:0];
          link_wdata = head_r;
          head_nxt   = new_r;
          len_nxt    = len_r + LEN_W'(1);
          state_nxt  = S_RESP;
        end else begin
          op_nxt    = OP_INS;
          cur_nxt   = head_r;
          cnt_nxt   = idx_r - LEN_W'(1);
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (cnt_r == '0) begin
          state_nxt = after_walk;
        end else begin
          link_re   = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        // The link just read is both the new position and the next address.
        cur_nxt = link_rd_r;
        cnt_nxt = cnt_r - LEN_W'(1);
        if (cnt_r == LEN_W'(1)) begin
          state_nxt = after_walk;
        end else begin
          link_re    = 1'b1;
          link_raddr = link_rd_r[ADDR_W-1:0];
        end
      end
      S_GRD: begin
        value_re  = 1'b1;
        state_nxt = S_GWAIT;
      end
      S_GWAIT: begin
        resp_value_nxt = value_rd_r;
        state_nxt      = S_RESP;
      end
      S_IRD: begin
        link_re   = 1'b1;
        state_nxt = S_IW1;
      end
      S_IW1: begin
        link_we    = 1'b1;
        link_waddr = new_r[ADDR_W-1:0];
        link_wdata = link_rd_r;
        state_nxt  = S_IW2;
      end
      S_IW2: begin
        link_we    = 1'b1;
        link_wdata = new_r;
        len_nxt    = len_r + LEN_W'(1);
        state_nxt  = S_RESP;
      end
      S_DHEAD: begin
        link_re    = 1'b1;
        link_raddr = victim_r[ADDR_W-1:0];
        state_nxt  = S_DLINK;
      end
      S_DPREV: begin
        link_re   = 1'b1;
        state_nxt = S_DGETV;
      end
      S_DGETV: begin
        victim_nxt = link_rd_r;
        link_re    = 1'b1;
        link_raddr = link_rd_r[ADDR_W-1:0];
        state_nxt  = S_DLINK;
      end
      S_DLINK: begin
        // Unhook the victim: its successor becomes the head or the
        // predecessor's link.
        if (del_head_r) begin
          head_nxt = link_rd_r;
        end else begin
          link_we    = 1'b1;
          link_wdata = link_rd_r;
        end
        state_nxt = S_DFREE;
      end
      S_DFREE: begin
        link_we    = 1'b1;
        link_waddr = victim_r[ADDR_W-1:0];
        link_wdata = free_r;
        free_nxt   = victim_r;
        len_nxt    = len_r - LEN_W'(1);
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = resp_value_r;
          out_status_nxt = resp_status_r;
          out_len_nxt    = POS_W'(CMP_W'(len_r));
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NULL_PTR;
      free_r      <= NULL_PTR;
      len_r       <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      len_r       <= len_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r          <= op_nxt;
    cur_r         <= cur_nxt;
    cnt_r         <= cnt_nxt;
    idx_r         <= idx_nxt;
    new_r         <= new_nxt;
    victim_r      <= victim_nxt;
    del_head_r    <= del_head_nxt;
    val_r         <= val_nxt;
    resp_value_r  <= resp_value_nxt;
    resp_status_r <= resp_status_nxt;
    out_value_r   <= out_value_nxt;
    out_status_r  <= out_status_nxt;
    out_len_r     <= out_len_nxt;
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rd_r <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (value_we) begin
      value_mem[value_waddr] <= value_wdata;
    end
    if (value_re) begin
      value_rd_r <= value_mem[value_raddr];
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_read_value   = out_value_r;
  assign out_status       = out_status_r;
  assign out_length_after = out_len_r;

  // The list can never hold more nodes than the store provides.
  a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CAP_LEN)
    else $error("list length exceeds the node store");

  // The sequencer never reads and writes the same link entry in one cycle.
  a_link_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(link_re && link_we && link_raddr == link_waddr))
    else $error("link memory read and write collide");

  // An empty list has no head, and a non-empty one has one, except in the
  // cycle between unhooking the head and counting the deletion.
  a_head_matches_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_DFREE |-> ((head_r == NULL_PTR) == (len_r == '0)))
    else $error("head pointer disagrees with list length");

  // A result is only loaded as the sequencer returns to idle.
  a_result_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && (!out_valid_r || out_ready)) |=>
      (out_valid_r && state_r == S_IDLE))
    else $error("result load and sequencer state out of step");

endmodule

// ===== test/indexed_linked_list_engine_tb.sv =====
// Self-checking testbench for indexed_linked_list_engine: directed and random
// list requests, each result checked against an in-bench list predictor.
// Depends on ille_pkg and on the indexed_linked_list_engine RTL.
`timescale 1ns / 1ps

module indexed_linked_list_engine_tb;

  localparam int MODE_W     = ille_pkg::MODE_W;
  localparam int POS_W      = ille_pkg::POS_W;
  localparam int VALUE_W    = ille_pkg::VALUE_W;
  localparam int STATUS_W   = ille_pkg::STATUS_W;

  localparam int CAPACITY   = 1024;
  localparam int CLK_HALF   = 5;
  localparam int RESET_CYCLES = 10;
  // No transaction on either channel for this many cycles means a hang. The
  // slowest correct request walks the whole store, plus the short idles of
  // both sides.
  localparam int STALL_LIMIT = 5 * (CAPACITY + 16);
  localparam int POS_MAX    = (1 << POS_W) - 1;

  // Mode codes that the block does not use; they must change nothing.
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

  // The read value reported by anything other than a successful get.
  localparam logic signed [VALUE_W-1:0] NO_VALUE  = -32'sd1;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic signed [VALUE_W-1:0] read_value;
    logic [STATUS_W-1:0]       status;
    logic [POS_W-1:0]          length_after;
  } list_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [MODE_W-1:0]         in_mode = ille_pkg::MODE_GET;
  logic [POS_W-1:0]          in_position = '0;
  logic signed [VALUE_W-1:0] in_item_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] out_read_value;
  logic [STATUS_W-1:0]       out_status;
  logic [POS_W-1:0]          out_length_after;

  // The list as the testbench believes it to be, head first. Which node of
  // the store holds a value cannot be seen from outside, so only the order of
  // values is kept. Every node handed out is either on the list or on the free
  // list, so the store is full exactly when the list holds CAPACITY entries.
  logic signed [VALUE_W-1:0] list_values[$];
  // Results owed by the block, oldest first.
  list_result_t              pending_results[$];
  int                        error_count = 0;
  // When clear, neither side inserts idle cycles.
  bit                        idle_on = 1'b1;
  int                        ready_hold = 0;

  indexed_linked_list_engine #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_position     (in_position),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_length_after(out_length_after)
  );

  always #CLK_HALF clk = ~clk;

  // Applies one request to the believed list and returns what the block must
  // report for it. Range checks come before the full check, so an insert at a
  // bad index into a full store reports the bad index.
  function automatic list_result_t predict_list_request(
    input logic [MODE_W-1:0]         mode,
    input logic [POS_W-1:0]          pos,
    input logic signed [VALUE_W-1:0] value
  );
    list_result_t res;
    int           idx;
    int           len;
    bit           full;
    idx = int'(pos);
    len = list_values.size();
    full = (len >= CAPACITY);
    res.read_value = NO_VALUE;
    res.status = ille_pkg::ST_RANGE;
    case (mode)
      ille_pkg::MODE_GET: begin
        if (idx < len) begin
          res.read_value = list_values[idx];
          res.status = ille_pkg::ST_DONE;
        end
      end
      ille_pkg::MODE_INS_HEAD: begin
        if (full) begin
          res.status = ille_pkg::ST_FULL;
        end else begin
          list_values.push_front(value);
          res.status = ille_pkg::ST_DONE;
        end
      end
      ille_pkg::MODE_APPEND: begin
        if (full) begin
          res.status = ille_pkg::ST_FULL;
        end else begin
          list_values.push_back(value);
          res.status = ille_pkg::ST_DONE;
        end
      end
      ille_pkg::MODE_INS_AT: begin
        if (idx <= len) begin
          if (full) begin
            res.status = ille_pkg::ST_FULL;
          end else begin
            if (idx == len) list_values.push_back(value);
            else list_values.insert(idx, value);
            res.status = ille_pkg::ST_DONE;
          end
        end
      end
      ille_pkg::MODE_DELETE: begin
        if (idx < len) begin
          list_values.delete(idx);
          res.status = ille_pkg::ST_DONE;
        end
      end
      default: begin
        // Spare modes leave the list alone and report a bad index.
      end
    endcase
    res.length_after = POS_W'(list_values.size());
    return res;
  endfunction

  // Sends one request. It is entered at a rising edge, either just after the
  // previous transaction or after a pause with in_valid low, and returns at
  // the edge where the block takes the transaction. in_valid is only lowered
  // when an idle gap follows, so a back-to-back request keeps it high.
  task automatic issue_request(
    input logic [MODE_W-1:0]         mode,
    input logic [POS_W-1:0]          pos,
    input logic signed [VALUE_W-1:0] value
  );
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_position   <= pos;
    in_item_value <= value;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_list_request(mode, pos, value));
  endtask

  // Holds the input side idle until every owed result has been taken.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Requests against an empty list: every index is bad, and an insert at the
  // index equal to the length is the only positional insert allowed.
  task automatic test_empty_list();
    issue_request(ille_pkg::MODE_GET, '0, $urandom());
    issue_request(ille_pkg::MODE_GET, POS_W'(POS_MAX), $urandom());
    issue_request(ille_pkg::MODE_DELETE, '0, $urandom());
    issue_request(ille_pkg::MODE_INS_AT, POS_W'(1), $urandom());
    for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++) begin
      issue_request(MODE_W'(m), POS_W'($urandom()), $urandom());
    end
    issue_request(ille_pkg::MODE_INS_AT, '0, 32'sd7);
    issue_request(ille_pkg::MODE_DELETE, '0, $urandom());
  endtask

  // Every mode on a short list, with the extreme values, inserts and deletes
  // at the head, in the middle and at the tail, and indexes just past the end.
  task automatic test_each_mode();
    issue_request(ille_pkg::MODE_INS_HEAD, POS_W'(POS_MAX), VALUE_MIN);
    issue_request(ille_pkg::MODE_APPEND, '0, VALUE_MAX);
    issue_request(ille_pkg::MODE_INS_HEAD, '0, '0);
    issue_request(ille_pkg::MODE_INS_AT, POS_W'(3), NO_VALUE);
    issue_request(ille_pkg::MODE_INS_AT, POS_W'(2), 32'sh5A5A_5A5A);
    issue_request(ille_pkg::MODE_INS_AT, POS_W'(6), $urandom());
    for (int p = 0; p <= 5; p++) begin
      issue_request(ille_pkg::MODE_GET, POS_W'(p), $urandom());
    end
    issue_request(ille_pkg::MODE_GET, POS_W'(CAPACITY), $urandom());
    issue_request(ille_pkg::MODE_DELETE, POS_W'(5), $urandom());
    issue_request(ille_pkg::MODE_DELETE, POS_W'(4), $urandom());
    issue_request(ille_pkg::MODE_DELETE, POS_W'(2), $urandom());
    issue_request(ille_pkg::MODE_DELETE, '0, $urandom());
    issue_request(ille_pkg::MODE_DELETE, POS_W'(CAPACITY), $urandom());
    // The freed nodes are taken again before fresh ones.
    issue_request(ille_pkg::MODE_APPEND, '0, 32'sh1234_5678);
    issue_request(ille_pkg::MODE_GET, POS_W'(2), $urandom());
  endtask

  // One random request. Most positions are valid for the current length; the
  // rest lie beyond it, up to the largest position the field can carry. Long
  // lists are steered back towards deletes to keep the walks affordable.
  task automatic issue_random_request();
    int                 len;
    int                 roll;
    bit                 good;
    bit                 is_insert;
    logic [MODE_W-1:0]  mode;
    logic [POS_W-1:0]   pos;
    len  = list_values.size();
    roll = $urandom_range(0, 99);
    good = ($urandom_range(0, 99) < 85);
    if (roll < 5) mode = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
    else if (roll < 30) mode = ille_pkg::MODE_GET;
    else if (roll < 42) mode = ille_pkg::MODE_INS_HEAD;
    else if (roll < 54) mode = ille_pkg::MODE_APPEND;
    else if (roll < 72) mode = ille_pkg::MODE_INS_AT;
    else mode = ille_pkg::MODE_DELETE;
    is_insert = (mode == ille_pkg::MODE_INS_HEAD || mode == ille_pkg::MODE_APPEND ||
                 mode == ille_pkg::MODE_INS_AT);
    if (len > 200 && is_insert && $urandom_range(0, 1) == 1) begin
      mode = ille_pkg::MODE_DELETE;
    end
    case (mode)
      ille_pkg::MODE_GET, ille_pkg::MODE_DELETE: begin
        if (len == 0) pos = POS_W'($urandom_range(0, POS_MAX));
        else if (good) pos = POS_W'($urandom_range(0, len - 1));
        else pos = POS_W'($urandom_range(len, POS_MAX));
      end
      ille_pkg::MODE_INS_AT: begin
        if (good) pos = POS_W'($urandom_range(0, len));
        else pos = POS_W'($urandom_range(len + 1, POS_MAX));
      end
      default: pos = POS_W'($urandom_range(0, POS_MAX));
    endcase
    issue_request(mode, pos, $urandom());
  endtask

  // Random traffic, with stretches in which neither side idles and with an
  // occasional pause on the input side until every result has come back.
  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (i % 150 == 149) wait_results_drained();
      issue_random_request();
    end
  endtask

  // Result side: takes each output transaction, compares it field by field
  // with the oldest owed result, then holds out_ready low for a random number
  // of cycles before the next one.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      out_ready  <= 1'b1;
      ready_hold = 0;
    end else if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing owed: read_value %0d, status %0d, length_after %0d",
               out_read_value, out_status, out_length_after);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, out_read_value);
          error_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          error_count++;
        end
        if (out_length_after !== want.length_after) begin
          $error("length_after: expected %0d, got %0d", want.length_after, out_length_after);
          error_count++;
        end
      end
      ready_hold = idle_on ? $urandom_range(0, 3) : 0;
      if (ready_hold != 0) out_ready <= 1'b0;
    end else if (!out_ready) begin
      ready_hold--;
      if (ready_hold <= 0) out_ready <= 1'b1;
    end
  end

  // Ends the run if neither channel moves a transaction for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("indexed_linked_list_engine_tb: done, errors");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_each_mode();
    wait_results_drained();
    test_random_traffic(550);
    wait_results_drained();
    // Room for any stray result; the slowest request walks the whole store.
    repeat (CAPACITY + 16) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("indexed_linked_list_engine_tb: done, clean");
    end else begin
      $display("indexed_linked_list_engine_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/ille_pkg.sv
src/indexed_linked_list_engine.sv
test/indexed_linked_list_engine_tb.sv
